>>> design/djqs_pkg.sv
// Package: types, constants and helpers for the deadline job queue server.
`timescale 1ns / 1ps

package djqs_pkg;

    localparam int MAX_WAIT = 8;
    localparam int TIME_W   = 32;
    localparam int ID_W     = 16;
    localparam int CFG_W    = 4;
    localparam int CNT_W    = $clog2(MAX_WAIT + 1);
    localparam int PTR_W    = (MAX_WAIT > 1) ? $clog2(MAX_WAIT) : 1;
    localparam int SUM_W    = CNT_W + 1;

    localparam logic [CFG_W-1:0]  CAP_RESET = CFG_W'(3);
    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

    localparam logic OP_ARRIVE  = 1'b0;
    localparam logic OP_FLUSH   = 1'b1;
    localparam logic KIND_DONE  = 1'b0;
    localparam logic KIND_ABORT = 1'b1;

    typedef enum logic
    {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed
    {
        logic              operation;
        logic [ID_W-1:0]   job_id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] duration;
        logic [TIME_W-1:0] timeout;
    } job_t;

    typedef struct packed
    {
        logic              kind;
        logic [ID_W-1:0]   job_id_res;
        logic [TIME_W-1:0] event_time;
        logic [TIME_W-1:0] delay;
        logic              last;
    } rec_t;

    typedef struct packed
    {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [TIME_W-1:0] duration;
        logic [TIME_W-1:0] deadline;
    } entry_t;

    function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        logic [TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
    endfunction

    function automatic logic [TIME_W-1:0] sat_sub(input logic [TIME_W-1:0] a,
                                                   input logic [TIME_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

endpackage

>>> design/deadline_job_queue_server.sv
// Top level: single server with a bounded waiting queue and per-job deadlines.
`timescale 1ns / 1ps

// One job beat is taken while the block is idle; the block then produces its
// result records, settling queued jobs oldest first, one per cycle while
// rec_stall does not hold the output register, then the record for the
// arriving job; a flush, or an arrival that ends without a record, takes a
// closing step in ST_RUN before the block is idle again. The waiting jobs
// live in a MAX_WAIT-entry memory read at the next head pointer every cycle,
// so each settle finds the following entry already registered.
// wait_capacity is written through cfg_wr_en / cfg_wr_data and is clamped to
// MAX_WAIT; write it only while the block is idle. The queue memory needs no
// clearing after reset.
module deadline_job_queue_server
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        job_valid,
    output logic                        job_stall,
    input  djqs_pkg::job_t              job,
    output logic                        rec_valid,
    input  logic                        rec_stall,
    output djqs_pkg::rec_t              rec,
    input  logic                        cfg_wr_en,
    input  logic [djqs_pkg::CFG_W-1:0]  cfg_wr_data
);

    djqs_pkg::state_t                  state_reg, state_next;
    logic [djqs_pkg::TIME_W-1:0]       free_reg, free_next;
    logic [djqs_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [djqs_pkg::PTR_W-1:0]        head_reg, head_next;
    logic [djqs_pkg::CFG_W-1:0]        cap_reg;
    djqs_pkg::job_t                    item_reg, item_next;
    logic                              out_valid_reg, out_valid_next;
    djqs_pkg::rec_t                    out_reg, out_next;

    djqs_pkg::entry_t                  mem [djqs_pkg::MAX_WAIT];
    djqs_pkg::entry_t                  rd_entry_reg;
    djqs_pkg::entry_t                  wr_entry;
    logic                              mem_we;
    logic [djqs_pkg::PTR_W-1:0]        wr_ptr;
    logic [djqs_pkg::SUM_W-1:0]        tail_sum;

    logic [djqs_pkg::CNT_W-1:0]        eff_cap;
    logic                              slot_free;
    logic                              settle_go;
    logic [djqs_pkg::TIME_W-1:0]       fin_time;
    logic                              st_kind;
    logic [djqs_pkg::TIME_W-1:0]       st_time;
    logic [djqs_pkg::TIME_W-1:0]       st_delay;
    logic [djqs_pkg::TIME_W-1:0]       st_free;
    logic [djqs_pkg::CNT_W-1:0]        st_count;
    logic [djqs_pkg::PTR_W-1:0]        st_head;
    logic                              st_last;

    assign job_stall = (state_reg != djqs_pkg::ST_IDLE);
    assign rec_valid = out_valid_reg;
    assign rec       = out_reg;
    assign slot_free = !out_valid_reg || !rec_stall;

    assign eff_cap = (int'(cap_reg) > djqs_pkg::MAX_WAIT)
                   ? djqs_pkg::CNT_W'(djqs_pkg::MAX_WAIT)
                   : djqs_pkg::CNT_W'(cap_reg);

    // tail slot = (head + count) mod MAX_WAIT
    always_comb
    begin
        tail_sum = djqs_pkg::SUM_W'(head_reg) + djqs_pkg::SUM_W'(count_reg);
        if (int'(tail_sum) >= djqs_pkg::MAX_WAIT)
            tail_sum = tail_sum - djqs_pkg::SUM_W'(djqs_pkg::MAX_WAIT);
        wr_ptr = djqs_pkg::PTR_W'(tail_sum);
    end

    assign wr_entry = '{id:       item_reg.job_id,
                        arrival:  item_reg.arrival,
                        duration: item_reg.duration,
                        deadline: item_reg.timeout};

    // settle the job at the queue head against the current free time
    always_comb
    begin
        fin_time = djqs_pkg::sat_add(free_reg, rd_entry_reg.duration);
        if (rd_entry_reg.deadline <= free_reg)
        begin
            st_kind  = djqs_pkg::KIND_ABORT;
            st_time  = free_reg;
            st_delay = djqs_pkg::sat_sub(free_reg, rd_entry_reg.arrival);
            st_free  = free_reg;
        end
        else if (fin_time <= rd_entry_reg.deadline)
        begin
            st_kind  = djqs_pkg::KIND_DONE;
            st_time  = fin_time;
            st_delay = djqs_pkg::sat_sub(djqs_pkg::sat_sub(fin_time, rd_entry_reg.arrival),
                                         rd_entry_reg.duration);
            st_free  = fin_time;
        end
        else
        begin
            st_kind  = djqs_pkg::KIND_ABORT;
            st_time  = rd_entry_reg.deadline;
            st_delay = djqs_pkg::sat_sub(rd_entry_reg.deadline, rd_entry_reg.arrival);
            st_free  = rd_entry_reg.deadline;
        end
        st_count = count_reg - djqs_pkg::CNT_W'(1);
        st_head  = (int'(head_reg) == djqs_pkg::MAX_WAIT - 1)
                 ? '0 : head_reg + djqs_pkg::PTR_W'(1);
        // last record unless another settle or a record for the arrival follows
        if (item_reg.operation == djqs_pkg::OP_FLUSH)
            st_last = (st_count == '0);
        else
            st_last = (item_reg.arrival < st_free) && (st_count < eff_cap);
    end

    assign settle_go = (count_reg != '0)
                    && ((item_reg.operation == djqs_pkg::OP_FLUSH)
                        || (item_reg.arrival >= free_reg));

    always_comb
    begin
        state_next     = state_reg;
        free_next      = free_reg;
        count_next     = count_reg;
        head_next      = head_reg;
        item_next      = item_reg;
        mem_we         = 1'b0;
        out_valid_next = out_valid_reg && rec_stall;
        out_next       = out_reg;

        unique case (state_reg)
            djqs_pkg::ST_IDLE:
            begin
                if (job_valid)
                begin
                    item_next  = job;
                    state_next = djqs_pkg::ST_RUN;
                end
            end
            djqs_pkg::ST_RUN:
            begin
                if (settle_go)
                begin
                    if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '{kind: st_kind, job_id_res: rd_entry_reg.id,
                                           event_time: st_time, delay: st_delay,
                                           last: st_last};
                        free_next      = st_free;
                        count_next     = st_count;
                        head_next      = st_head;
                    end
                end
                else if (item_reg.operation == djqs_pkg::OP_FLUSH)
                begin
                    state_next = djqs_pkg::ST_IDLE;
                end
                else if (item_reg.arrival < free_reg)
                begin
                    if (count_reg < eff_cap)
                    begin
                        mem_we     = 1'b1;
                        count_next = count_reg + djqs_pkg::CNT_W'(1);
                        state_next = djqs_pkg::ST_IDLE;
                    end
                    else if (slot_free)
                    begin
                        out_valid_next = 1'b1;
                        out_next       = '{kind: djqs_pkg::KIND_ABORT,
                                           job_id_res: item_reg.job_id,
                                           event_time: item_reg.arrival,
                                           delay: '0, last: 1'b1};
                        state_next     = djqs_pkg::ST_IDLE;
                    end
                end
                else if (slot_free)
                begin
                    free_next      = djqs_pkg::sat_add(item_reg.arrival, item_reg.duration);
                    out_valid_next = 1'b1;
                    out_next       = '{kind: djqs_pkg::KIND_DONE,
                                       job_id_res: item_reg.job_id,
                                       event_time: free_next,
                                       delay: '0, last: 1'b1};
                    state_next     = djqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = djqs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= djqs_pkg::ST_IDLE;
            free_reg      <= '0;
            count_reg     <= '0;
            head_reg      <= '0;
            cap_reg       <= djqs_pkg::CAP_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            free_reg      <= free_next;
            count_reg     <= count_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
        out_reg  <= out_next;
    end

    // queue memory: read at the next head so the entry is registered for the next cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[wr_ptr] <= wr_entry;
        rd_entry_reg <= mem[head_next];
    end

endmodule

>>> verif/tb.sv
// Testbench for the deadline job queue server: directed and random job beats, scoreboarded.
`timescale 1ns / 1ps

module tb;

    localparam int RUN_LIMIT = 400000;
    localparam int LONG_HOLD = 400;

    logic                              clk;
    logic                              rst_n       = 1'b0;
    logic                              job_valid   = 1'b0;
    logic                              job_stall;
    djqs_pkg::job_t                    job_beat    = '0;
    logic                              rec_valid;
    logic                              rec_stall   = 1'b0;
    djqs_pkg::rec_t                    rec;
    logic                              cfg_wr_en   = 1'b0;
    logic [djqs_pkg::CFG_W-1:0]        cfg_wr_data = '0;

    djqs_pkg::job_t                    beats_to_send[$];
    djqs_pkg::rec_t                    records_due[$];

    // predictor state
    djqs_pkg::entry_t                  waiting[djqs_pkg::MAX_WAIT];
    logic [djqs_pkg::TIME_W-1:0]       srv_free    = '0;
    int                                q_count     = 0;
    int                                q_head      = 0;
    logic [djqs_pkg::CFG_W-1:0]        cap_setting = djqs_pkg::CAP_RESET;

    int                                send_idle_pct = 0;
    int                                stall_pct     = 0;
    bit                                pressure_on   = 1'b0;
    bit                                hold_done     = 1'b0;
    int                                hold_left     = 0;
    int                                fail_count    = 0;
    int                                cycle_count   = 0;
    logic [djqs_pkg::TIME_W-1:0]       arrival_cursor = '0;

    deadline_job_queue_server u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .job_valid   (job_valid),
        .job_stall   (job_stall),
        .job         (job_beat),
        .rec_valid   (rec_valid),
        .rec_stall   (rec_stall),
        .rec         (rec),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic logic [djqs_pkg::TIME_W-1:0] t_add(
        input logic [djqs_pkg::TIME_W-1:0] a,
        input logic [djqs_pkg::TIME_W-1:0] b);
        logic [djqs_pkg::TIME_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[djqs_pkg::TIME_W] ? djqs_pkg::TIME_MAX : s[djqs_pkg::TIME_W-1:0];
    endfunction

    function automatic logic [djqs_pkg::TIME_W-1:0] t_sub(
        input logic [djqs_pkg::TIME_W-1:0] a,
        input logic [djqs_pkg::TIME_W-1:0] b);
        return (a > b) ? (a - b) : '0;
    endfunction

    task automatic push_rec(input logic k, input logic [djqs_pkg::ID_W-1:0] id,
                            input logic [djqs_pkg::TIME_W-1:0] t,
                            input logic [djqs_pkg::TIME_W-1:0] d);
        djqs_pkg::rec_t r;
        r.kind       = k;
        r.job_id_res = id;
        r.event_time = t;
        r.delay      = d;
        r.last       = 1'b0;
        records_due.push_back(r);
    endtask

    task automatic settle_oldest();
        djqs_pkg::entry_t            e;
        logic [djqs_pkg::TIME_W-1:0] t;
        logic [djqs_pkg::TIME_W-1:0] fin;
        e   = waiting[q_head];
        t   = srv_free;
        fin = t_add(t, e.duration);
        if (e.deadline <= t)
            push_rec(djqs_pkg::KIND_ABORT, e.id, t, t_sub(t, e.arrival));
        else if (fin <= e.deadline)
        begin
            srv_free = fin;
            push_rec(djqs_pkg::KIND_DONE, e.id, fin,
                     t_sub(t_sub(fin, e.arrival), e.duration));
        end
        else
        begin
            srv_free = e.deadline;
            push_rec(djqs_pkg::KIND_ABORT, e.id, e.deadline, t_sub(e.deadline, e.arrival));
        end
        q_head  = (q_head + 1) % djqs_pkg::MAX_WAIT;
        q_count = q_count - 1;
    endtask

    task automatic schedule_job(input djqs_pkg::job_t j);
        int               before_n;
        int               cap;
        djqs_pkg::entry_t e;
        djqs_pkg::rec_t   r;
        before_n = records_due.size();
        cap      = (int'(cap_setting) > djqs_pkg::MAX_WAIT) ? djqs_pkg::MAX_WAIT
                                                            : int'(cap_setting);
        if (j.operation == djqs_pkg::OP_FLUSH)
        begin
            while (q_count > 0)
                settle_oldest();
        end
        else
        begin
            while (q_count > 0 && j.arrival >= srv_free)
                settle_oldest();
            if (j.arrival < srv_free)
            begin
                if (q_count < cap)
                begin
                    e.id       = j.job_id;
                    e.arrival  = j.arrival;
                    e.duration = j.duration;
                    e.deadline = j.timeout;
                    waiting[(q_head + q_count) % djqs_pkg::MAX_WAIT] = e;
                    q_count = q_count + 1;
                end
                else
                    push_rec(djqs_pkg::KIND_ABORT, j.job_id, j.arrival, '0);
            end
            else
            begin
                srv_free = t_add(j.arrival, j.duration);
                push_rec(djqs_pkg::KIND_DONE, j.job_id, srv_free, '0);
            end
        end
        if (records_due.size() > before_n)
        begin
            r = records_due.pop_back();
            r.last = 1'b1;
            records_due.push_back(r);
        end
    endtask

    task automatic compare_field(input string nm, input logic [djqs_pkg::TIME_W-1:0] e,
                                 input logic [djqs_pkg::TIME_W-1:0] a);
        if (e !== a)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, nm, e, a);
            fail_count = fail_count + 1;
        end
    endtask

    // sender
    always @(posedge clk)
    begin
        if (!rst_n)
            job_valid <= 1'b0;
        else if (!job_valid || !job_stall)
        begin
            if (beats_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                job_valid <= 1'b1;
                job_beat  <= beats_to_send.pop_front();
            end
            else
                job_valid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            rec_stall <= 1'b0;
        else
        begin
            if (pressure_on && !hold_done)
            begin
                hold_left = LONG_HOLD;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                rec_stall <= 1'b1;
            end
            else
                rec_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // monitor and scoreboard
    always @(posedge clk)
    begin
        djqs_pkg::rec_t want;
        if (rst_n)
        begin
            if (rec_valid && !rec_stall)
            begin
                if (records_due.size() == 0)
                begin
                    $display("%0t: unexpected record, id %0h kind %0d time %0h delay %0h",
                             $time, rec.job_id_res, rec.kind, rec.event_time, rec.delay);
                    fail_count = fail_count + 1;
                end
                else
                begin
                    want = records_due.pop_front();
                    compare_field("kind", djqs_pkg::TIME_W'(want.kind),
                                  djqs_pkg::TIME_W'(rec.kind));
                    compare_field("job_id_res", djqs_pkg::TIME_W'(want.job_id_res),
                                  djqs_pkg::TIME_W'(rec.job_id_res));
                    compare_field("event_time", want.event_time, rec.event_time);
                    compare_field("delay", want.delay, rec.delay);
                    compare_field("last", djqs_pkg::TIME_W'(want.last),
                                  djqs_pkg::TIME_W'(rec.last));
                end
            end
            if (job_valid && !job_stall)
                schedule_job(job_beat);
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == RUN_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic djqs_pkg::job_t arrival_beat(
        input logic [djqs_pkg::ID_W-1:0]   id,
        input logic [djqs_pkg::TIME_W-1:0] arr,
        input logic [djqs_pkg::TIME_W-1:0] dur,
        input logic [djqs_pkg::TIME_W-1:0] dl);
        djqs_pkg::job_t j;
        j.operation = djqs_pkg::OP_ARRIVE;
        j.job_id    = id;
        j.arrival   = arr;
        j.duration  = dur;
        j.timeout   = dl;
        return j;
    endfunction

    function automatic djqs_pkg::job_t flush_beat();
        djqs_pkg::job_t j;
        j.operation = djqs_pkg::OP_FLUSH;
        j.job_id    = djqs_pkg::ID_W'($urandom);
        j.arrival   = $urandom;
        j.duration  = $urandom;
        j.timeout   = $urandom;
        return j;
    endfunction

    function automatic djqs_pkg::job_t random_beat();
        djqs_pkg::job_t j;
        int unsigned    pick;
        pick = $urandom_range(99);
        if (pick < 4)
            return flush_beat();
        if (pick < 7)
            arrival_cursor = t_sub(arrival_cursor, $urandom_range(1, 50));
        else
            arrival_cursor = arrival_cursor + $urandom_range(0, 40);
        j.operation = djqs_pkg::OP_ARRIVE;
        j.job_id    = djqs_pkg::ID_W'($urandom);
        j.arrival   = arrival_cursor;
        j.duration  = ($urandom_range(9) == 0) ? '0 : $urandom_range(1, 60);
        pick = $urandom_range(99);
        if (pick < 10)
            j.timeout = $urandom;
        else if (pick < 25)
            j.timeout = t_sub(j.arrival, $urandom_range(0, 20));
        else if (pick < 45)
            j.timeout = j.arrival + j.duration / 2 + $urandom_range(0, 40);
        else
            j.timeout = j.arrival + j.duration + $urandom_range(0, 200);
        return j;
    endfunction

    task automatic wait_quiet();
        while (beats_to_send.size() != 0 || job_valid || records_due.size() != 0)
            @(posedge clk);
        repeat (16) @(posedge clk);
    endtask

    task automatic write_cap(input logic [djqs_pkg::CFG_W-1:0] v);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        cap_setting = v;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_phase(input logic [djqs_pkg::CFG_W-1:0] cap, input int idle,
                             input int stall, input bit press, input int n);
        wait_quiet();
        write_cap(cap);
        send_idle_pct = idle;
        stall_pct     = stall;
        pressure_on   = press;
        repeat (n) beats_to_send.push_back(random_beat());
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // reset capacity: served, queued, full, mixed settling, empty flush
        beats_to_send.push_back(arrival_beat(16'h0000, 32'd0, 32'd100, 32'hFFFF_FFFF));
        beats_to_send.push_back(arrival_beat(16'hFFFF, 32'd10, 32'd50, 32'd200));
        beats_to_send.push_back(arrival_beat(16'd2, 32'd20, 32'd500, 32'd300));
        beats_to_send.push_back(arrival_beat(16'd3, 32'd30, 32'd10, 32'd40));
        beats_to_send.push_back(arrival_beat(16'd4, 32'd40, 32'd10, 32'd90));
        beats_to_send.push_back(arrival_beat(16'd5, 32'd1000, 32'd0, 32'd0));
        beats_to_send.push_back(flush_beat());

        // zero capacity: a waiting arrival is turned away at once
        wait_quiet();
        write_cap(4'd0);
        beats_to_send.push_back(arrival_beat(16'd8, 32'd2000, 32'd100, 32'd100000));
        beats_to_send.push_back(arrival_beat(16'd9, 32'd2050, 32'd10, 32'd100000));

        // capacity above the queue depth: fill, overflow, then nine records
        wait_quiet();
        write_cap(4'd15);
        for (int i = 0; i < djqs_pkg::MAX_WAIT; i++)
            beats_to_send.push_back(arrival_beat(16'(10 + i), 32'(2060 + i), 32'd10,
                                                 32'd100000));
        beats_to_send.push_back(arrival_beat(16'd18, 32'd2068, 32'd10, 32'd100000));
        beats_to_send.push_back(arrival_beat(16'd19, 32'd3000, 32'd1, 32'd100000));

        arrival_cursor = 32'd3000;
        run_phase(4'd1,  0,  0,  1'b0, 90);
        run_phase(4'd6,  54, 0,  1'b0, 90);
        run_phase(4'd2,  0,  54, 1'b0, 90);
        run_phase(4'd12, 25, 25, 1'b0, 90);
        run_phase(4'd5,  0,  0,  1'b1, 100);

        // saturation and a late arrival that goes back in time
        run_phase(4'd8, 0, 0, 1'b0, 0);
        beats_to_send.push_back(arrival_beat(16'hA5A5, 32'hFFFF_FF00, 32'hFFFF_FFFF,
                                             32'hFFFF_FFFF));
        beats_to_send.push_back(arrival_beat(16'h5A5A, 32'd5, 32'd5, 32'd600));
        beats_to_send.push_back(flush_beat());
        beats_to_send.push_back(arrival_beat(16'h1234, 32'hFFFF_FFFF, 32'd0, 32'd0));

        wait_quiet();
        repeat (20) @(posedge clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
